// ----- hdl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and types for the first-fit block allocator: field widths,
// request kinds, result status codes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

	// fixed field widths of the item and result channels
	localparam int KIND_W    = 1;
	localparam int REQ_W     = 21;
	localparam int IN_ADDR_W = 20;
	localparam int GRANT_W   = 20;
	localparam int STATUS_W  = 2;
	localparam int POOL_W    = 21;

	// defaults for the top-level parameters
	localparam int DEF_MAX_BLOCKS = 64;
	localparam int DEF_ADDR_BITS  = 20;

	// pool size after reset, before saturation to the address space
	localparam int POOL_RESET = 1048576;

	// allocation granule in bytes
	localparam int GRAIN = 8;

	localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ----- hdl/ffba_ram.sv -----
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a byte pool. An address-sorted free table and a
// grant-ordered used table live in two RAMs and are walked by one sequencer
// around a single shared subtract/compare unit.
//
//  channel   dir  handshake               payload
//  in        in   in_valid / in_ready     kind, request_bytes, free_address
//  out       out  out_valid / out_ready   status, granted_address
//  cfg       in   cfg_valid / cfg_ready   pool_size
//
// an allocate scans the free table at one entry a cycle, then shifts down
// when a block is taken whole; a free searches the used table and shifts it
// up, then scans the free table for the position and shifts it to make room,
// one RAM read port per table setting the pace.
// reset or a pool_size write rebuilds the free table in the S_INIT state.
// a finished result waits in the output register; the next transaction can
// be taken meanwhile, but a new result holds until the old one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = ffba_pkg::DEF_MAX_BLOCKS,
	parameter int ADDR_BITS  = ffba_pkg::DEF_ADDR_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ffba_pkg::POOL_W-1:0]   pool_size,
	// requests
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ffba_pkg::KIND_W-1:0]   kind,
	input  wire logic [ffba_pkg::REQ_W-1:0]    request_bytes,
	input  wire logic [ffba_pkg::IN_ADDR_W-1:0] free_address,
	// results
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [ffba_pkg::STATUS_W-1:0] status,
	output logic      [ffba_pkg::GRANT_W-1:0]  granted_address
);

	import ffba_pkg::*;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int LEN_W  = ADDR_BITS + 1;
	localparam int NEED_W = REQ_W + 1;
	localparam int ALU_A  = (LEN_W > NEED_W) ? LEN_W : NEED_W;
	localparam int ALU_W  = (ALU_A > IN_ADDR_W) ? ALU_A : IN_ADDR_W;
	localparam int ENT_W  = ADDR_BITS + LEN_W;
	localparam int PW     = (LEN_W > POOL_W) ? LEN_W : POOL_W;

	localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_BLOCKS);
	localparam logic [PW-1:0]    POOL_LIMIT = PW'(1) << ADDR_BITS;
	localparam logic [PW-1:0]    POOL_RST_W = PW'(POOL_RESET);
	localparam logic [LEN_W-1:0] POOL_RST   =
		LEN_W'((POOL_RST_W > POOL_LIMIT) ? POOL_LIMIT : POOL_RST_W);

	typedef enum logic [8:0] {
		S_INIT    = 9'b000000001,
		S_IDLE    = 9'b000000010,
		S_ASCAN   = 9'b000000100,
		S_ASHIFT  = 9'b000001000,
		S_FSCAN   = 9'b000010000,
		S_FUSHIFT = 9'b000100000,
		S_FPOS    = 9'b001000000,
		S_FINS    = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

	state_t             state_q, state_d;
	logic [LEN_W-1:0]   pool_q, pool_d;
	logic [CNT_W-1:0]   free_cnt_q, free_cnt_d;
	logic [CNT_W-1:0]   used_cnt_q, used_cnt_d;
	logic [CNT_W-1:0]   rd_ptr_q, rd_ptr_d;
	logic               pv_s1, pv_d;
	logic [IDX_W-1:0]   pidx_s1;
	logic [NEED_W-1:0]  need_q, need_d;
	logic [IN_ADDR_W-1:0] addr_q, addr_d;
	logic [ADDR_BITS-1:0] blk_start_q, blk_start_d;
	logic [LEN_W-1:0]   blk_len_q, blk_len_d;
	logic [CNT_W-1:0]   pos_q, pos_d;
	status_t            st_q, st_d;
	logic [ADDR_BITS-1:0] grant_q, grant_d;
	logic               out_valid_q, out_valid_d;
	status_t            out_st_q;
	logic [ADDR_BITS-1:0] out_grant_q;
	logic               out_load;

	// ram ports
	logic               free_we, used_we;
	logic [IDX_W-1:0]   free_waddr, used_waddr;
	logic [ENT_W-1:0]   free_wdata, used_wdata;
	logic [ENT_W-1:0]   free_rdata, used_rdata;
	logic [IDX_W-1:0]   rd_addr_c;
	logic               issue_c;
	logic [CNT_W-1:0]   rd_dec_c;

	logic [ADDR_BITS-1:0] frd_start, urd_start;
	logic [LEN_W-1:0]     frd_len, urd_len;

	// shared subtract / compare unit
	logic [ALU_W-1:0]   alu_a, alu_b;
	logic [ALU_W:0]     diff_c;
	logic               lt_c, eq_c;

	logic [NEED_W-1:0]  need_sum_c;
	logic [ADDR_BITS-1:0] split_start_c;
	logic [CNT_W:0]     total_c;
	logic [PW-1:0]      cfg_ext_c;
	logic               cfg_acc;

	assign frd_start = free_rdata[ENT_W-1:LEN_W];
	assign frd_len   = free_rdata[LEN_W-1:0];
	assign urd_start = used_rdata[ENT_W-1:LEN_W];
	assign urd_len   = used_rdata[LEN_W-1:0];

	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_INIT);
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;

	assign need_sum_c    = NEED_W'(request_bytes) + NEED_W'(GRAIN - 1);
	assign split_start_c = ADDR_BITS'(ALU_W'(frd_start) + ALU_W'(need_q));
	assign total_c       = {1'b0, free_cnt_q} + {1'b0, used_cnt_q};
	assign cfg_ext_c     = PW'(pool_size);
	assign rd_dec_c      = rd_ptr_q - CNT_W'(1);

	// read address and issue for the table walk
	always_comb begin
		issue_c   = 1'b0;
		rd_addr_c = rd_ptr_q[IDX_W-1:0];
		case (state_q)
			S_ASCAN, S_ASHIFT, S_FPOS: begin
				issue_c = rd_ptr_q < free_cnt_q;
			end
			S_FUSHIFT: begin
				issue_c = rd_ptr_q < used_cnt_q;
			end
			S_FSCAN: begin
				issue_c   = rd_ptr_q != '0;
				rd_addr_c = rd_dec_c[IDX_W-1:0];
			end
			S_FINS: begin
				issue_c   = rd_ptr_q > pos_q;
				rd_addr_c = rd_dec_c[IDX_W-1:0];
			end
			default: begin
				issue_c = 1'b0;
			end
		endcase
	end

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			S_ASCAN: begin
				alu_a = ALU_W'(frd_len);
				alu_b = ALU_W'(need_q);
			end
			S_FSCAN: begin
				alu_a = ALU_W'(urd_start);
				alu_b = ALU_W'(addr_q);
			end
			S_FPOS: begin
				alu_a = ALU_W'(blk_start_q);
				alu_b = ALU_W'(frd_start);
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign diff_c = {1'b0, alu_a} - {1'b0, alu_b};
	assign lt_c   = diff_c[ALU_W];
	assign eq_c   = diff_c[ALU_W-1:0] == '0;

	// sequencer
	always_comb begin
		state_d     = state_q;
		pool_d      = pool_q;
		free_cnt_d  = free_cnt_q;
		used_cnt_d  = used_cnt_q;
		pv_d        = issue_c;
		need_d      = need_q;
		addr_d      = addr_q;
		blk_start_d = blk_start_q;
		blk_len_d   = blk_len_q;
		pos_d       = pos_q;
		st_d        = st_q;
		grant_d     = grant_q;
		out_load    = 1'b0;
		free_we     = 1'b0;
		free_waddr  = pidx_s1;
		free_wdata  = free_rdata;
		used_we     = 1'b0;
		used_waddr  = pidx_s1;
		used_wdata  = used_rdata;

		if (state_q == S_FSCAN || state_q == S_FINS) begin
			rd_ptr_d = issue_c ? rd_dec_c : rd_ptr_q;
		end else begin
			rd_ptr_d = issue_c ? rd_ptr_q + CNT_W'(1) : rd_ptr_q;
		end

		case (state_q)
			S_INIT: begin
				free_we    = 1'b1;
				free_waddr = '0;
				free_wdata = {{ADDR_BITS{1'b0}}, pool_q};
				free_cnt_d = CNT_W'(1);
				used_cnt_d = '0;
				state_d    = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					if (kind == KIND_ALLOC) begin
						need_d   = need_sum_c & ~NEED_W'(GRAIN - 1);
						rd_ptr_d = '0;
						state_d  = S_ASCAN;
					end else begin
						addr_d   = free_address;
						grant_d  = '0;
						rd_ptr_d = used_cnt_q;
						state_d  = S_FSCAN;
					end
				end
			end
			S_ASCAN: begin
				if (pv_s1 && !lt_c) begin
					pv_d = 1'b0;
					if (eq_c) begin
						if (used_cnt_q >= MAX_CNT) begin
							st_d    = ST_FULL;
							grant_d = '0;
							state_d = S_DONE;
						end else begin
							// whole block taken, close the gap behind it
							used_we    = 1'b1;
							used_waddr = used_cnt_q[IDX_W-1:0];
							used_wdata = {frd_start, frd_len};
							used_cnt_d = used_cnt_q + CNT_W'(1);
							grant_d    = frd_start;
							st_d       = ST_OK;
							rd_ptr_d   = CNT_W'(pidx_s1) + CNT_W'(1);
							state_d    = S_ASHIFT;
						end
					end else if (total_c >= {1'b0, MAX_CNT}) begin
						st_d    = ST_FULL;
						grant_d = '0;
						state_d = S_DONE;
					end else begin
						// split: head granted, tail stays in place
						used_we    = 1'b1;
						used_waddr = used_cnt_q[IDX_W-1:0];
						used_wdata = {frd_start, LEN_W'(need_q)};
						used_cnt_d = used_cnt_q + CNT_W'(1);
						free_we    = 1'b1;
						free_waddr = pidx_s1;
						free_wdata = {split_start_c, diff_c[LEN_W-1:0]};
						grant_d    = frd_start;
						st_d       = ST_OK;
						state_d    = S_DONE;
					end
				end else if (!pv_s1 && !issue_c) begin
					st_d    = ST_NO_FIT;
					grant_d = '0;
					state_d = S_DONE;
				end
			end
			S_ASHIFT: begin
				if (pv_s1) begin
					free_we    = 1'b1;
					free_waddr = pidx_s1 - IDX_W'(1);
				end else if (!issue_c) begin
					free_cnt_d = free_cnt_q - CNT_W'(1);
					state_d    = S_DONE;
				end
			end
			S_FSCAN: begin
				if (pv_s1 && eq_c) begin
					pv_d = 1'b0;
					if (free_cnt_q >= MAX_CNT) begin
						st_d    = ST_NOT_FOUND;
						state_d = S_DONE;
					end else begin
						blk_start_d = urd_start;
						blk_len_d   = urd_len;
						rd_ptr_d    = CNT_W'(pidx_s1) + CNT_W'(1);
						state_d     = S_FUSHIFT;
					end
				end else if (!pv_s1 && !issue_c) begin
					st_d    = ST_NOT_FOUND;
					state_d = S_DONE;
				end
			end
			S_FUSHIFT: begin
				if (pv_s1) begin
					used_we    = 1'b1;
					used_waddr = pidx_s1 - IDX_W'(1);
				end else if (!issue_c) begin
					used_cnt_d = used_cnt_q - CNT_W'(1);
					rd_ptr_d   = '0;
					state_d    = S_FPOS;
				end
			end
			S_FPOS: begin
				// first free block that starts above the freed one
				if (pv_s1 && lt_c) begin
					pv_d     = 1'b0;
					pos_d    = CNT_W'(pidx_s1);
					rd_ptr_d = free_cnt_q;
					state_d  = S_FINS;
				end else if (!pv_s1 && !issue_c) begin
					pos_d    = free_cnt_q;
					rd_ptr_d = free_cnt_q;
					state_d  = S_FINS;
				end
			end
			S_FINS: begin
				if (pv_s1) begin
					free_we    = 1'b1;
					free_waddr = pidx_s1 + IDX_W'(1);
				end else if (!issue_c) begin
					free_we    = 1'b1;
					free_waddr = pos_q[IDX_W-1:0];
					free_wdata = {blk_start_q, blk_len_q};
					free_cnt_d = free_cnt_q + CNT_W'(1);
					st_d       = ST_OK;
					state_d    = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase

		// a pool write rebuilds both tables
		if (cfg_acc) begin
			pool_d  = LEN_W'((cfg_ext_c > POOL_LIMIT) ? POOL_LIMIT : cfg_ext_c);
			state_d = S_INIT;
		end

		out_valid_d = out_load || (out_valid_q && !out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			pool_q      <= POOL_RST;
			free_cnt_q  <= CNT_W'(1);
			used_cnt_q  <= '0;
			rd_ptr_q    <= '0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pool_q      <= pool_d;
			free_cnt_q  <= free_cnt_d;
			used_cnt_q  <= used_cnt_d;
			rd_ptr_q    <= rd_ptr_d;
			pv_s1       <= pv_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		pidx_s1     <= rd_addr_c;
		need_q      <= need_d;
		addr_q      <= addr_d;
		blk_start_q <= blk_start_d;
		blk_len_q   <= blk_len_d;
		pos_q       <= pos_d;
		st_q        <= st_d;
		grant_q     <= grant_d;
		if (out_load) begin
			out_st_q    <= st_q;
			out_grant_q <= grant_q;
		end
	end

	ffba_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_BLOCKS)
	) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (free_wdata),
		.raddr (rd_addr_c),
		.rdata (free_rdata)
	);

	ffba_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_BLOCKS)
	) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.raddr (rd_addr_c),
		.rdata (used_rdata)
	);

	assign out_valid       = out_valid_q;
	assign status          = out_st_q;
	assign granted_address = GRANT_W'(out_grant_q);

`ifndef SYNTH
	// a whole-block grant counts the used entry before the free one is dropped
	a_entry_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ASHIFT || total_c <= {1'b0, MAX_CNT})
		else $error("free and used entries exceed the table bound");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the completion step");

	a_start_walk: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> (state_q == S_ASCAN || state_q == S_FSCAN))
		else $error("accepted transaction did not start a table walk");

	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> state_q == S_INIT)
		else $error("pool write did not rebuild the tables");
`endif

endmodule

`default_nettype wire
